### rtl/core/cbc_pkg.sv
package cbc_pkg;

    localparam int BLK_IN_W  = 20;
    localparam int CYL_W     = 20;
    localparam int SEC_W     = 16;
    localparam int WAY_OUT_W = 6;
    localparam int SPC_W     = 16;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // register index taken from paddr above the byte offset
    localparam logic [APB_AW-3:0] REG_SPC = '0;
    localparam logic [SPC_W-1:0]  SPC_RESET = 16'd1;

    typedef enum logic {
        K_ACCESS = 1'b0,
        K_FLUSH  = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [BLK_IN_W-1:0] block;
    } t_cmd;

    typedef struct packed {
        logic             done;
        logic [CYL_W-1:0] cyl;
        logic [SEC_W-1:0] sec;
    } t_div_rsp;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way_index;
        logic                 writeback_needed;
        logic [CYL_W-1:0]     writeback_cylinder;
        logic [SEC_W-1:0]     writeback_sector;
        logic                 fill_needed;
        logic [CYL_W-1:0]     fill_cylinder;
        logic [SEC_W-1:0]     fill_sector;
        logic                 last;
    } t_result;

endpackage

### rtl/core/cbc_front.sv
module cbc_front import cbc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_action,
    input  logic [BLK_IN_W-1:0] i_block_number,
    output logic                o_cmd_valid,
    output t_cmd                o_cmd,
    input  logic                i_cmd_pop
);

    // two-entry command queue between intake and the policy engine
    t_cmd       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    t_cmd       cmd_in;
    logic       push;
    logic       pop;

    always_comb begin
        cmd_in.kind  = i_action ? K_FLUSH : K_ACCESS;
        cmd_in.block = i_block_number;
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cmd_in;
        end
    end

endmodule

### rtl/core/cbc_div.sv
module cbc_div import cbc_pkg::*; #(
    parameter int BLOCK_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [BLOCK_BITS-1:0] i_dividend,
    input  logic [SPC_W-1:0]      i_divisor,
    output t_div_rsp              o_rsp
);

    localparam int CNT_W = $clog2(BLOCK_BITS + 1);

    typedef enum logic {
        D_IDLE,
        D_RUN
    } t_state;

    t_state                r_state;
    logic [BLOCK_BITS-1:0] r_q;
    logic [SEC_W-1:0]      r_rem;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_zero;
    logic                  r_done;
    logic [SEC_W:0]        shifted;
    logic                  ge;
    logic [SEC_W-1:0]      rem_next;

    // restoring division, one quotient bit per cycle
    always_comb begin
        shifted  = {r_rem, r_q[BLOCK_BITS-1]};
        ge       = (shifted >= {1'b0, i_divisor});
        rem_next = ge ? SEC_W'(shifted - {1'b0, i_divisor}) : SEC_W'(shifted);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_zero  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        if (i_divisor == '0) begin
                            // zero divisor: all-ones cylinder, sector is the low bits
                            r_zero <= 1'b1;
                            r_rem  <= SEC_W'(i_dividend);
                            r_done <= 1'b1;
                        end else begin
                            r_zero  <= 1'b0;
                            r_rem   <= '0;
                            r_q     <= i_dividend;
                            r_cnt   <= CNT_W'(BLOCK_BITS);
                            r_state <= D_RUN;
                        end
                    end
                end
                D_RUN: begin
                    r_rem <= rem_next;
                    r_q   <= {r_q[BLOCK_BITS-2:0], ge};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        o_rsp.cyl  = r_zero ? '1 : CYL_W'(r_q);
        o_rsp.sec  = r_rem;
    end

endmodule

### rtl/core/cbc_back.sv
module cbc_back import cbc_pkg::*; #(
    parameter int NUM_WAYS   = 16,
    parameter int BLOCK_BITS = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_pop,
    input  logic [SPC_W-1:0] i_spc,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_result          o_res
);

    localparam int WAY_W = $clog2(NUM_WAYS);

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_CLEAR = 2'd1,
        ST_REF   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SWEEP,
        S_DIV_WB,
        S_DIV_FILL,
        S_FL_SCAN,
        S_FL_DIV,
        S_EMIT
    } t_state;

    t_state                r_state;
    t_status               r_status [NUM_WAYS];
    logic [BLOCK_BITS-1:0] r_tag_mem [NUM_WAYS];
    logic [BLOCK_BITS-1:0] r_tag_rd;
    logic [WAY_W-1:0]      r_ptr;
    logic [WAY_W-1:0]      n_ptr;
    logic [WAY_W-1:0]      r_hand;
    logic [BLOCK_BITS-1:0] r_blk;
    t_result               r_res;
    logic                  r_more;
    logic                  r_out_valid;
    t_result               r_out;
    logic                  r_div_start;
    logic [BLOCK_BITS-1:0] r_div_dvd;
    t_div_rsp              div_rsp;

    t_status               cur_status;
    logic                  cur_valid;
    logic                  tag_match;
    logic                  ptr_last;
    logic [WAY_W-1:0]      ptr_inc;
    logic                  slot_free;
    logic [NUM_WAYS-1:0]   valid_vec;
    logic                  more_above;
    logic                  tag_we;

    always_comb begin
        cur_status = r_status[r_ptr];
        cur_valid  = (cur_status != ST_EMPTY);
        tag_match  = cur_valid && (r_tag_rd == r_blk);
        ptr_last   = (r_ptr == WAY_W'(NUM_WAYS - 1));
        ptr_inc    = ptr_last ? '0 : r_ptr + WAY_W'(1);
        slot_free  = !r_out_valid || i_out_ready;
        more_above = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            valid_vec[w] = (r_status[w] != ST_EMPTY);
            if (valid_vec[w] && (WAY_W'(w) > r_ptr)) begin
                more_above = 1'b1;
            end
        end
    end

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign tag_we    = (r_state == S_DIV_FILL) && div_rsp.done;

    // tag read pointer; r_tag_rd holds tag[r_ptr] but is stale after a write
    always_comb begin
        n_ptr = r_ptr;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_ptr = '0;
                end
            end
            S_LOOK: begin
                if (!tag_match) begin
                    n_ptr = ptr_last ? r_hand : ptr_inc;
                end
            end
            S_SWEEP: begin
                if (cur_status == ST_REF) begin
                    n_ptr = ptr_inc;
                end
            end
            S_FL_SCAN: begin
                if (!cur_valid && !ptr_last) begin
                    n_ptr = ptr_inc;
                end
            end
            S_EMIT: begin
                if (slot_free && r_more) begin
                    n_ptr = ptr_inc;
                end
            end
            default: begin
                n_ptr = r_ptr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            r_tag_mem[r_ptr] <= r_blk;
        end
        r_tag_rd <= r_tag_mem[n_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_hand      <= '0;
            r_more      <= 1'b0;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
            for (int w = 0; w < NUM_WAYS; w++) begin
                r_status[w] <= ST_EMPTY;
            end
        end else begin
            r_ptr       <= n_ptr;
            r_div_start <= 1'b0;
            if (r_state == S_EMIT && slot_free) begin
                r_out_valid <= 1'b1;
                r_out       <= r_res;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_blk <= BLOCK_BITS'(i_cmd.block);
                        if (i_cmd.kind == K_FLUSH) begin
                            if (valid_vec == '0) begin
                                r_res   <= '{last: 1'b1, default: '0};
                                r_more  <= 1'b0;
                                r_state <= S_EMIT;
                            end else begin
                                r_state <= S_FL_SCAN;
                            end
                        end else begin
                            r_state <= S_LOOK;
                        end
                    end
                end
                S_LOOK: begin
                    if (tag_match) begin
                        r_status[r_ptr] <= ST_REF;
                        r_res           <= '{hit: 1'b1, way_index: WAY_OUT_W'(r_ptr),
                                             last: 1'b1, default: '0};
                        r_more          <= 1'b0;
                        r_state         <= S_EMIT;
                    end else if (ptr_last) begin
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (cur_status == ST_REF) begin
                        r_status[r_ptr] <= ST_CLEAR;
                    end else begin
                        r_res       <= '{way_index: WAY_OUT_W'(r_ptr),
                                         writeback_needed: cur_valid, fill_needed: 1'b1,
                                         last: 1'b1, default: '0};
                        r_more      <= 1'b0;
                        r_div_start <= 1'b1;
                        if (cur_valid) begin
                            r_div_dvd <= r_tag_rd;
                            r_state   <= S_DIV_WB;
                        end else begin
                            r_div_dvd <= r_blk;
                            r_state   <= S_DIV_FILL;
                        end
                    end
                end
                S_DIV_WB: begin
                    if (div_rsp.done) begin
                        r_res       <= '{hit: r_res.hit, way_index: r_res.way_index,
                                         writeback_needed: r_res.writeback_needed,
                                         writeback_cylinder: div_rsp.cyl,
                                         writeback_sector: div_rsp.sec,
                                         fill_needed: r_res.fill_needed,
                                         fill_cylinder: r_res.fill_cylinder,
                                         fill_sector: r_res.fill_sector,
                                         last: r_res.last};
                        r_div_start <= 1'b1;
                        r_div_dvd   <= r_blk;
                        r_state     <= S_DIV_FILL;
                    end
                end
                S_DIV_FILL: begin
                    if (div_rsp.done) begin
                        r_res           <= '{hit: r_res.hit, way_index: r_res.way_index,
                                             writeback_needed: r_res.writeback_needed,
                                             writeback_cylinder: r_res.writeback_cylinder,
                                             writeback_sector: r_res.writeback_sector,
                                             fill_needed: r_res.fill_needed,
                                             fill_cylinder: div_rsp.cyl,
                                             fill_sector: div_rsp.sec,
                                             last: r_res.last};
                        r_status[r_ptr] <= ST_REF;
                        r_hand          <= ptr_inc;
                        r_state         <= S_EMIT;
                    end
                end
                S_FL_SCAN: begin
                    if (cur_valid) begin
                        r_div_start <= 1'b1;
                        r_div_dvd   <= r_tag_rd;
                        r_state     <= S_FL_DIV;
                    end else if (ptr_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_FL_DIV: begin
                    if (div_rsp.done) begin
                        r_res   <= '{way_index: WAY_OUT_W'(r_ptr), writeback_needed: 1'b1,
                                     writeback_cylinder: div_rsp.cyl,
                                     writeback_sector: div_rsp.sec,
                                     last: !more_above, default: '0};
                        r_more  <= more_above;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_state <= r_more ? S_FL_SCAN : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    cbc_div #(
        .BLOCK_BITS (BLOCK_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_dvd),
        .i_divisor  (i_spc),
        .o_rsp      (div_rsp)
    );

    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

### rtl/core/clock_block_cache_controller_core.sv
// Hit: the ways are compared in order in S_LOOK, one tag compare per cycle over the tag memory port.
// Miss: a lookup over all NUM_WAYS ways, up to NUM_WAYS+1 hand steps, then serial divisions of
// the write-back tag (if the victim is valid) and of the new block; one item in the engine
// at a time, so a new command is taken only once the last result has entered the output register.
// Flush: the ways are scanned in order, and each valid way gets a serial division and a result.
// Reset (synchronous, active low) empties all ways, zeroes the hand, clears the queue and output
// and sets sectors_per_cylinder to 1; the tag memory is not cleared.
module clock_block_cache_controller_core import cbc_pkg::*; #(
    parameter int NUM_WAYS   = 16,
    parameter int BLOCK_BITS = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_action,
    input  logic [BLK_IN_W-1:0] i_block_number,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_hit,
    output logic [WAY_OUT_W-1:0] o_way_index,
    output logic                o_writeback_needed,
    output logic [CYL_W-1:0]    o_writeback_cylinder,
    output logic [SEC_W-1:0]    o_writeback_sector,
    output logic                o_fill_needed,
    output logic [CYL_W-1:0]    o_fill_cylinder,
    output logic [SEC_W-1:0]    o_fill_sector,
    output logic                o_last,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    logic [SPC_W-1:0] r_spc_val;
    logic             cmd_valid;
    t_cmd             cmd;
    logic             cmd_pop;
    t_result          res;
    logic             sel_spc;

    assign pready  = 1'b1;
    assign sel_spc = (paddr[APB_AW-1:2] == REG_SPC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spc_val <= SPC_RESET;
        end else if (psel && penable && pwrite && pready && sel_spc) begin
            r_spc_val <= pwdata[SPC_W-1:0];
        end
    end

    assign prdata = sel_spc ? APB_DW'(r_spc_val) : '0;

    cbc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_block_number (i_block_number),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_pop      (cmd_pop)
    );

    cbc_back #(
        .NUM_WAYS   (NUM_WAYS),
        .BLOCK_BITS (BLOCK_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_spc       (r_spc_val),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (res)
    );

    assign o_hit                = res.hit;
    assign o_way_index          = res.way_index;
    assign o_writeback_needed   = res.writeback_needed;
    assign o_writeback_cylinder = res.writeback_cylinder;
    assign o_writeback_sector   = res.writeback_sector;
    assign o_fill_needed        = res.fill_needed;
    assign o_fill_cylinder      = res.fill_cylinder;
    assign o_fill_sector        = res.fill_sector;
    assign o_last               = res.last;

endmodule

### rtl/core/cbc_checker.sv
module cbc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_hit,
    input logic [5:0]  o_way_index,
    input logic        o_writeback_needed,
    input logic [19:0] o_writeback_cylinder,
    input logic [15:0] o_writeback_sector,
    input logic        o_fill_needed,
    input logic        o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_way_index) && $stable(o_last)
            && $stable(o_hit))
        else $error("result transaction changed while stalled");

    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> !o_writeback_needed && !o_fill_needed && o_last)
        else $error("hit result carries transfer requests");

    a_fill_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_fill_needed |-> o_last && !o_hit)
        else $error("fill result is not a single final access result");

    a_wb_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_writeback_needed |->
            (o_writeback_cylinder == 20'd0) && (o_writeback_sector == 16'd0))
        else $error("write-back fields set without a write-back");

endmodule

bind clock_block_cache_controller_core cbc_checker u_cbc_checker (.*);

### bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbc_pkg::*;

    localparam int NUM_WAYS    = 16;
    localparam int BLOCK_BITS  = 20;
    localparam int STALL_LIMIT = 5000;
    localparam int POOL_SIZE   = 24;

    localparam logic [APB_AW-3:0] REG_NONE = REG_SPC + 1'b1;

    typedef enum logic [1:0] {
        WAY_EMPTY,
        WAY_CLEAR,
        WAY_REF
    } t_way_state;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_action = 1'b0;
    logic [BLK_IN_W-1:0]  i_block_number = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_hit;
    logic [WAY_OUT_W-1:0] o_way_index;
    logic                 o_writeback_needed;
    logic [CYL_W-1:0]     o_writeback_cylinder;
    logic [SEC_W-1:0]     o_writeback_sector;
    logic                 o_fill_needed;
    logic [CYL_W-1:0]     o_fill_cylinder;
    logic [SEC_W-1:0]     o_fill_sector;
    logic                 o_last;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // predictor state
    t_way_state       way_state [NUM_WAYS] = '{default: WAY_EMPTY};
    logic [BLK_IN_W-1:0] way_tag [NUM_WAYS];
    int               hand_pos = 0;
    logic [SPC_W-1:0] spc_model = SPC_RESET;
    t_result          pending_results [$];

    int n_errors = 0;
    int send_idle_pct = 0;
    int rcv_idle_pct = 0;
    int hold_req = 0;
    int hold_left = 0;
    int stall_count = 0;

    clock_block_cache_controller_core #(
        .NUM_WAYS   (NUM_WAYS),
        .BLOCK_BITS (BLOCK_BITS)
    ) dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_action             (i_action),
        .i_block_number       (i_block_number),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_hit                (o_hit),
        .o_way_index          (o_way_index),
        .o_writeback_needed   (o_writeback_needed),
        .o_writeback_cylinder (o_writeback_cylinder),
        .o_writeback_sector   (o_writeback_sector),
        .o_fill_needed        (o_fill_needed),
        .o_fill_cylinder      (o_fill_cylinder),
        .o_fill_sector        (o_fill_sector),
        .o_last               (o_last),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // cylinder/sector split; a zero divisor gives an all-ones cylinder
    function automatic void split_block(input logic [BLK_IN_W-1:0] blk,
                                        output logic [CYL_W-1:0] cyl,
                                        output logic [SEC_W-1:0] sec);
        if (spc_model == '0) begin
            cyl = '1;
            sec = blk[SEC_W-1:0];
        end else begin
            cyl = CYL_W'(blk / spc_model);
            sec = SEC_W'(blk % spc_model);
        end
    endfunction

    function automatic void predict_cache_op(input t_kind kind, input logic [BLK_IN_W-1:0] blk);
        t_result r;
        int hit_way;
        int victim;
        hit_way = -1;
        if (kind == K_FLUSH) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (way_state[w] != WAY_EMPTY) begin
                    r = '0;
                    r.way_index = WAY_OUT_W'(w);
                    r.writeback_needed = 1'b1;
                    split_block(way_tag[w], r.writeback_cylinder, r.writeback_sector);
                    pending_results.push_back(r);
                end
            end
            if (pending_results.size() == 0 || kind == K_FLUSH) begin
                // nothing valid: a single all-zero result closes the flush; else the last way's result is marked last
                r = '0;
                if (pending_results.size() != 0 && !pending_results[$].last)
                    r = pending_results.pop_back();
                r.last = 1'b1;
                pending_results.push_back(r);
            end
            return;
        end

        r = '0;
        r.last = 1'b1;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (hit_way < 0 && way_state[w] != WAY_EMPTY && way_tag[w] == blk)
                hit_way = w;
        end
        if (hit_way >= 0) begin
            way_state[hit_way] = WAY_REF;
            r.hit = 1'b1;
            r.way_index = WAY_OUT_W'(hit_way);
        end else begin
            for (int steps = 0; steps <= NUM_WAYS; steps++) begin
                if (way_state[hand_pos] != WAY_REF)
                    break;
                way_state[hand_pos] = WAY_CLEAR;
                hand_pos = (hand_pos + 1) % NUM_WAYS;
            end
            victim = hand_pos;
            r.way_index = WAY_OUT_W'(victim);
            if (way_state[victim] != WAY_EMPTY) begin
                r.writeback_needed = 1'b1;
                split_block(way_tag[victim], r.writeback_cylinder, r.writeback_sector);
            end
            r.fill_needed = 1'b1;
            split_block(blk, r.fill_cylinder, r.fill_sector);
            way_tag[victim] = blk;
            way_state[victim] = WAY_REF;
            hand_pos = (victim + 1) % NUM_WAYS;
        end
        pending_results.push_back(r);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    // result side: check each transaction, then pick next ready
    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no transaction pending: way %0d", o_way_index);
                n_errors++;
            end else begin
                r = pending_results.pop_front();
                check_field("hit", 32'(r.hit), 32'(o_hit));
                check_field("way_index", 32'(r.way_index), 32'(o_way_index));
                check_field("writeback_needed", 32'(r.writeback_needed),
                            32'(o_writeback_needed));
                check_field("writeback_cylinder", 32'(r.writeback_cylinder),
                            32'(o_writeback_cylinder));
                check_field("writeback_sector", 32'(r.writeback_sector),
                            32'(o_writeback_sector));
                check_field("fill_needed", 32'(r.fill_needed), 32'(o_fill_needed));
                check_field("fill_cylinder", 32'(r.fill_cylinder), 32'(o_fill_cylinder));
                check_field("fill_sector", 32'(r.fill_sector), 32'(o_fill_sector));
                check_field("last", 32'(r.last), 32'(o_last));
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_req > 0) begin
            hold_left = hold_req - 1;
            hold_req = 0;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_count = 0;
        else
            stall_count++;
        if (stall_count == STALL_LIMIT) begin
            $display("clock_block_cache_controller_core test failed");
            $finish;
        end
    end

    task automatic send_item(input t_kind kind, input logic [BLK_IN_W-1:0] blk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= kind;
        i_block_number <= blk;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        predict_cache_op(kind, blk);
    endtask

    task automatic drain_results(input int tail);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    // register writes only with the engine idle; sectors_per_cylinder is read back after every write
    task automatic set_sectors(input logic [APB_AW-3:0] idx, input logic [APB_DW-1:0] data);
        drain_results(8);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx == REG_SPC)
            spc_model = data[SPC_W-1:0];
        pwrite <= 1'b0;
        penable <= 1'b0;
        paddr <= {REG_SPC, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        check_field("sectors_per_cylinder", 32'(spc_model), 32'(prdata[SPC_W-1:0]));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_empty_flush();
        send_item(K_FLUSH, BLK_IN_W'($urandom));
    endtask

    task automatic test_fill_and_hit();
        send_item(K_ACCESS, '0);
        send_item(K_ACCESS, '1);
        send_item(K_ACCESS, '0);
        send_item(K_FLUSH, '0);
    endtask

    task automatic test_divisor_extremes();
        set_sectors(REG_NONE, 32'h0000_0007);
        set_sectors(REG_SPC, 32'hFFFF_FFFF);
        send_item(K_ACCESS, '1);
        send_item(K_ACCESS, 20'hFFFFE);
        for (int k = 0; k < 13; k++)
            send_item(K_ACCESS, 20'h5A5A0 + BLK_IN_W'(k) * 20'h01011);
        // all ways referenced: the hand goes all the way round
        send_item(K_ACCESS, 20'h12345);
        set_sectors(REG_SPC, 32'h0);
        send_item(K_ACCESS, 20'hFEDCB);
        send_item(K_FLUSH, '1);
    endtask

    task automatic test_backpressure();
        set_sectors(REG_SPC, 32'd3);
        send_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_req = 400;
        for (int k = 0; k < 30; k++)
            send_item(K_ACCESS, BLK_IN_W'($urandom));
        drain_results(8);
    endtask

    task automatic test_random_traffic(input int n_items, input int snd_pct, input int rcv_pct,
                                       input logic [SPC_W-1:0] spc);
        logic [BLK_IN_W-1:0] pool [POOL_SIZE];
        int pick;
        set_sectors(REG_SPC, 32'(spc));
        send_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        foreach (pool[k])
            pool[k] = BLK_IN_W'($urandom);
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(99);
            if (pick < 4)
                send_item(K_FLUSH, BLK_IN_W'($urandom));
            else if (pick < 78)
                send_item(K_ACCESS, pool[$urandom_range(POOL_SIZE - 1)]);
            else
                send_item(K_ACCESS, BLK_IN_W'($urandom));
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 37;
        rcv_idle_pct = 55;
        test_empty_flush();
        test_fill_and_hit();
        test_divisor_extremes();
        test_random_traffic(150, 37, 55, SPC_W'($urandom_range(1, 65535)));
        test_random_traffic(150, 55, 37, SPC_W'($urandom_range(2, 9)));
        test_random_traffic(150, 0, 0, 16'd1);
        test_backpressure();
        drain_results(100);
        if (n_errors == 0)
            $display("clock_block_cache_controller_core test passed");
        else
            $display("clock_block_cache_controller_core test failed");
        $finish;
    end

endmodule

### filelist.f
rtl/core/cbc_pkg.sv
rtl/core/cbc_front.sv
rtl/core/cbc_div.sv
rtl/core/cbc_back.sv
rtl/core/clock_block_cache_controller_core.sv
rtl/core/cbc_checker.sv
bench/tb.sv
